// ===== sv/sabb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabb_pkg
// Shared types, codes and helpers of the scaled alpha bitmap blit unit.
// ----------------------------------------------------------------------------
package sabb_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PLOT = 1'b1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_SIZE   = 3'd0,
    REG_TARGET_SIZE   = 3'd1,
    REG_TARGET_ORIGIN = 3'd2,
    REG_BACKGROUND    = 3'd3,
    REG_CLIP_MIN      = 3'd4,
    REG_CLIP_MAX      = 3'd5,
    REG_FRAME_SIZE    = 3'd6,
    REG_UNUSED        = 3'd7
  } cfg_reg_t;

  localparam logic [31:0] SIZE_RESET  = 32'd4194368;
  localparam logic [31:0] FRAME_RESET = 32'd268439552;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
  localparam logic [16:0] RECIP_255    = 17'd32897;

  // item state traveling down the pipeline beside the valid bit
  typedef struct packed {
    logic        op;
    logic        ok;
    logic [11:0] load_index;
    logic [31:0] load_word;
    logic [23:0] addr;
  } meta_t;

  // exact x / 255 for 16-bit x whose quotient fits in 8 bits
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * {16'd0, RECIP_255};
    return p[30:23];
  endfunction

endpackage

// ===== sv/sabb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabb_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sabb_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 13,
  parameter int Q_W   = 13
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);
  localparam int CW = NUM_W + DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;
    logic [CW-1:0]    trial;
    logic [NUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
    end

    always_comb begin
      trial   = CW'(den_in) << (Q_W - 1 - i);
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (CW'(rem_in) >= trial) begin
        rem_nxt = rem_in - trial[NUM_W-1:0];
        quo_nxt[Q_W-1-i] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      quo_r[i] <= quo_nxt;
      den_r[i] <= den_in;
    end
  end

  assign quo_o = quo_r[Q_W-1];

endmodule

// ===== sv/sabb_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabb_store
// Source bitmap memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sabb_store #(
  parameter int WORDS = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

// ===== sv/sabb_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabb_blend
// Two-stage alpha blend of a source pixel over the background colour.
// ----------------------------------------------------------------------------
module sabb_blend (
  input  logic        clk,
  input  logic [31:0] col_i,
  input  logic [23:0] bg_i,
  output logic [31:0] colour_o,
  output logic        clear_o
);
  import sabb_pkg::*;

  logic [15:0] pc_r [3];
  logic [15:0] pb_r [3];
  logic [31:0] col_r;
  logic [7:0]  alpha;
  logic [7:0]  inv;
  logic [31:0] colour_r;
  logic [31:0] colour_nxt;
  logic        clear_r;
  logic [8:0]  sum [3];

  assign alpha = col_i[31:24];
  assign inv   = ALPHA_OPAQUE - alpha;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      pc_r[c] <= {8'd0, col_i[8*c +: 8]} * {8'd0, alpha};
      pb_r[c] <= {8'd0, bg_i[8*c +: 8]} * {8'd0, inv};
    end
    col_r <= col_i;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = {1'b0, div255(pc_r[c])} + {1'b0, div255(pb_r[c])};
    end
    if (col_r[31:24] == ALPHA_OPAQUE) begin
      colour_nxt = col_r;
    end else begin
      colour_nxt = {ALPHA_OPAQUE, sum[2][7:0], sum[1][7:0], sum[0][7:0]};
    end
  end

  always_ff @(posedge clk) begin
    colour_r <= colour_nxt;
    clear_r  <= (col_r[31:24] == ALPHA_CLEAR);
  end

  assign colour_o = colour_r;
  assign clear_o  = clear_r;

endmodule

// ===== sv/scaled_alpha_bitmap_blit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_alpha_bitmap_blit_unit
// Nearest-neighbour scaled ARGB blit with alpha blending over a background.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: start high while busy is low. busy stays low, so a beat can
//   be given every cycle. op load writes a source word, op plot maps one
//   destination offset to a framebuffer write.
//   Result beat: out_strobe high for one cycle per plot beat, carrying
//   out_write_enable, out_frame_address and out_pixel_colour. Loads give no
//   result beat.
//   Path: a plot passes the input register, the range and position stage,
//   the two pipelined restoring dividers (one quotient bit per stage) with
//   the side line beside them, the source index, store access, blend and
//   output registers.
//   Throughput: one beat per cycle, loads and plots mixed freely.
//   Loads write the store at the same stage where plots read it, so the
//   order of beats is kept exactly.
//   Configuration: cfg_valid/cfg_ready write channel, always ready; write it
//   only while the pipeline is empty.
//   Reset: rst_n low clears all valid bits and restores register defaults;
//   the source store holds no defined data until loaded.
//   The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module scaled_alpha_bitmap_blit_unit #(
  parameter int SOURCE_WORDS  = 4096,
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [11:0]                   in_load_index,
  input  logic [31:0]                   in_load_word,
  input  logic [11:0]                   in_offset_x,
  input  logic [11:0]                   in_offset_y,
  output logic                          out_strobe,
  output logic                          out_write_enable,
  output logic [23:0]                   out_frame_address,
  output logic [31:0]                   out_pixel_colour,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sabb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import sabb_pkg::*;

  localparam int DIM_W   = $clog2(MAX_DIMENSION) + 1;
  localparam int NUM_W   = 12 + DIM_W;
  localparam int AW      = $clog2(SOURCE_WORDS);
  localparam int LATENCY = DIM_W + 7;

  // configuration registers
  logic [31:0] source_size_r, target_size_r, target_origin_r;
  logic [23:0] background_r;
  logic [31:0] clip_min_r, clip_max_r, frame_size_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_size_r   <= SIZE_RESET;
      target_size_r   <= SIZE_RESET;
      target_origin_r <= '0;
      background_r    <= '0;
      clip_min_r      <= '0;
      clip_max_r      <= FRAME_RESET;
      frame_size_r    <= FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_SIZE:   source_size_r   <= cfg_data;
        REG_TARGET_SIZE:   target_size_r   <= cfg_data;
        REG_TARGET_ORIGIN: target_origin_r <= cfg_data;
        REG_BACKGROUND:    background_r    <= cfg_data[23:0];
        REG_CLIP_MIN:      clip_min_r      <= cfg_data;
        REG_CLIP_MAX:      clip_max_r      <= cfg_data;
        REG_FRAME_SIZE:    frame_size_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] dim_of(input logic [15:0] h);
    logic [DIM_W-1:0] v;
    if (h == 16'd0) begin
      v = DIM_W'(1);
    end else if ({16'd0, h} > 32'(MAX_DIMENSION)) begin
      v = DIM_W'(MAX_DIMENSION);
    end else begin
      v = h[DIM_W-1:0];
    end
    return v;
  endfunction

  logic [DIM_W-1:0] sw, sh, tw, th;
  assign sw = dim_of(source_size_r[15:0]);
  assign sh = dim_of(source_size_r[31:16]);
  assign tw = dim_of(target_size_r[15:0]);
  assign th = dim_of(target_size_r[31:16]);

  // stage 1: input register
  logic        s1_vld_r;
  logic        s1_op_r;
  logic [11:0] s1_lidx_r;
  logic [31:0] s1_lword_r;
  logic [11:0] s1_dx_r, s1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_op_r    <= in_op;
    s1_lidx_r  <= in_load_index;
    s1_lword_r <= in_load_word;
    s1_dx_r    <= in_offset_x;
    s1_dy_r    <= in_offset_y;
  end

  // stage 2: range, position, visibility, scale products
  logic signed [17:0] px_nxt, py_nxt;
  logic               in_range, visible;
  logic signed [17:0] cx0, cx1, cy0, cy1;

  always_comb begin
    px_nxt   = 18'(signed'(target_origin_r[15:0])) + signed'({6'd0, s1_dx_r});
    py_nxt   = 18'(signed'(target_origin_r[31:16])) + signed'({6'd0, s1_dy_r});
    cx0      = 18'(signed'(clip_min_r[15:0]));
    cy0      = 18'(signed'(clip_min_r[31:16]));
    cx1      = 18'(signed'(clip_max_r[15:0]));
    cy1      = 18'(signed'(clip_max_r[31:16]));
    in_range = ({4'd0, s1_dx_r} < 16'(tw)) && ({4'd0, s1_dy_r} < 16'(th));
    visible  = (px_nxt >= cx0) && (px_nxt < cx1) && (py_nxt >= cy0) && (py_nxt < cy1)
            && (px_nxt >= 18'sd0) && (px_nxt < signed'({2'b0, frame_size_r[15:0]}))
            && (py_nxt >= 18'sd0) && (py_nxt < signed'({2'b0, frame_size_r[31:16]}));
  end

  logic             s2_vld_r;
  logic             s2_op_r, s2_ok_r;
  logic [11:0]      s2_lidx_r;
  logic [31:0]      s2_lword_r;
  logic [15:0]      s2_px_r, s2_py_r;
  logic [NUM_W-1:0] s2_nx_r, s2_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_op_r    <= s1_op_r;
    s2_ok_r    <= in_range && visible;
    s2_lidx_r  <= s1_lidx_r;
    s2_lword_r <= s1_lword_r;
    s2_px_r    <= px_nxt[15:0];
    s2_py_r    <= py_nxt[15:0];
    s2_nx_r    <= NUM_W'(s1_dx_r) * NUM_W'(sw);
    s2_ny_r    <= NUM_W'(s1_dy_r) * NUM_W'(sh);
  end

  // dividers with side line
  logic [DIM_W-1:0] sx, sy;

  sabb_div #(.NUM_W(NUM_W), .DEN_W(DIM_W), .Q_W(DIM_W)) u_div_x (
    .clk   (clk),
    .num_i (s2_nx_r),
    .den_i (tw),
    .quo_o (sx)
  );

  sabb_div #(.NUM_W(NUM_W), .DEN_W(DIM_W), .Q_W(DIM_W)) u_div_y (
    .clk   (clk),
    .num_i (s2_ny_r),
    .den_i (th),
    .quo_o (sy)
  );

  logic [31:0] addr_prod;
  meta_t       line_nxt;
  meta_t       line_r [DIM_W];
  logic        line_vld_r [DIM_W];

  always_comb begin
    addr_prod           = {16'd0, s2_py_r} * {16'd0, frame_size_r[15:0]};
    line_nxt.op         = s2_op_r;
    line_nxt.ok         = s2_ok_r;
    line_nxt.load_index = s2_lidx_r;
    line_nxt.load_word  = s2_lword_r;
    line_nxt.addr       = addr_prod[23:0] + {8'd0, s2_px_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIM_W; i++) begin
        line_vld_r[i] <= 1'b0;
      end
    end else begin
      line_vld_r[0] <= s2_vld_r;
      for (int i = 1; i < DIM_W; i++) begin
        line_vld_r[i] <= line_vld_r[i-1];
      end
    end
    line_r[0] <= line_nxt;
    for (int i = 1; i < DIM_W; i++) begin
      line_r[i] <= line_r[i-1];
    end
  end

  // stage 3: source index
  logic [2*DIM_W:0] idx_full;
  logic             s3_vld_r;
  meta_t            s3_meta_r;
  logic [AW-1:0]    s3_idx_r;

  assign idx_full = (2*DIM_W+1)'(sy) * (2*DIM_W+1)'(sw) + (2*DIM_W+1)'(sx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= line_vld_r[DIM_W-1];
    end
    s3_meta_r <= line_r[DIM_W-1];
    s3_idx_r  <= idx_full[AW-1:0];
  end

  // stage 4: store access
  logic        st_we;
  logic [31:0] st_rdata;
  logic        s4_vld_r;
  meta_t       s4_meta_r;

  assign st_we = s3_vld_r && (s3_meta_r.op == OP_LOAD)
              && ({20'd0, s3_meta_r.load_index} < 32'(SOURCE_WORDS));

  sabb_store #(.WORDS(SOURCE_WORDS), .AW(AW)) u_store (
    .clk     (clk),
    .we_i    (st_we),
    .waddr_i (AW'(s3_meta_r.load_index)),
    .wdata_i (s3_meta_r.load_word),
    .raddr_i (s3_idx_r),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_meta_r <= s3_meta_r;
  end

  // stages 5 and 6: blend
  logic [31:0] colour;
  logic        clear;
  logic        s5_vld_r, s6_vld_r;
  meta_t       s5_meta_r, s6_meta_r;

  sabb_blend u_blend (
    .clk      (clk),
    .col_i    (st_rdata),
    .bg_i     (background_r),
    .colour_o (colour),
    .clear_o  (clear)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
    s5_meta_r <= s4_meta_r;
    s6_meta_r <= s5_meta_r;
  end

  // output register
  logic        out_strobe_r, out_we_r;
  logic [23:0] out_addr_r;
  logic [31:0] out_colour_r;
  logic        we_nxt;

  assign we_nxt = s6_meta_r.ok && !clear;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s6_vld_r && (s6_meta_r.op == OP_PLOT);
    end
    out_we_r     <= we_nxt;
    out_addr_r   <= we_nxt ? s6_meta_r.addr : '0;
    out_colour_r <= we_nxt ? colour : '0;
  end

  assign out_strobe        = out_strobe_r;
  assign out_write_enable  = out_we_r;
  assign out_frame_address = out_addr_r;
  assign out_pixel_colour  = out_colour_r;

endmodule

// ===== sv/sabb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabb_checker
// Port-level checks of the blit unit, bound to the top level.
// ----------------------------------------------------------------------------
module sabb_checker #(
  parameter int LAT = 20
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_op,
  input logic        out_strobe,
  input logic        out_write_enable,
  input logic [23:0] out_frame_address,
  input logic [31:0] out_pixel_colour
);
  localparam int CW = $clog2(LAT + 1) + 1;

  logic [CW-1:0] since_rst_r;
  logic          warm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_rst_r <= '0;
    end else if (since_rst_r <= CW'(LAT)) begin
      since_rst_r <= since_rst_r + CW'(1);
    end
  end

  assign warm = (since_rst_r > CW'(LAT));

  a_plot_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    warm && $past(start && !busy && in_op, LAT) |-> out_strobe)
    else $error("plot beat lost");

  a_no_phantom_beat: assert property (@(posedge clk) disable iff (!rst_n)
    warm && out_strobe |-> $past(start && !busy && in_op, LAT))
    else $error("result beat without plot");

  a_written_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_write_enable |-> out_pixel_colour[31:24] == 8'hFF)
    else $error("written pixel not opaque");

  a_skip_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_write_enable |-> out_frame_address == '0 && out_pixel_colour == '0)
    else $error("skipped pixel carries data");

endmodule

bind scaled_alpha_bitmap_blit_unit sabb_checker #(.LAT(LATENCY)) u_sabb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_op             (in_op),
  .out_strobe        (out_strobe),
  .out_write_enable  (out_write_enable),
  .out_frame_address (out_frame_address),
  .out_pixel_colour  (out_pixel_colour)
);

// ===== sim/scaled_alpha_bitmap_blit_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_alpha_bitmap_blit_unit_tb
// Drives load and plot beats with bursty timing through several register
// settings, predicts every framebuffer write and checks each result beat.
// ----------------------------------------------------------------------------
module scaled_alpha_bitmap_blit_unit_tb;
  import sabb_pkg::*;

  localparam int STORE_WORDS = 4096;
  localparam int MAX_DIM     = 4096;
  localparam int DRAIN       = 40;
  localparam longint LIMIT   = 400000;

  typedef struct packed {
    logic        op;
    logic [11:0] load_index;
    logic [31:0] load_word;
    logic [11:0] offset_x;
    logic [11:0] offset_y;
  } beat_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] frame_address;
    logic [31:0] pixel_colour;
  } pixel_write_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_op;
  logic [11:0] in_load_index;
  logic [31:0] in_load_word;
  logic [11:0] in_offset_x;
  logic [11:0] in_offset_y;
  logic out_strobe;
  logic out_write_enable;
  logic [23:0] out_frame_address;
  logic [31:0] out_pixel_colour;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  scaled_alpha_bitmap_blit_unit dut (.*);

  beat_t        pending_beats[$];
  pixel_write_t expected_writes[$];
  logic [31:0]  src_words[STORE_WORDS];
  bit           src_loaded[STORE_WORDS];
  logic [31:0]  regs[7];
  int           errors, plots, loads, writes_seen, burst_left, gap_left;
  longint       cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int dimension(input logic [15:0] half);
    int v;
    v = half;
    if (v < 1) v = 1;
    if (v > MAX_DIM) v = MAX_DIM;
    return v;
  endfunction

  function automatic int source_entry(input beat_t b);
    int sw, sh, tw, th;
    sw = dimension(regs[REG_SOURCE_SIZE][15:0]);
    sh = dimension(regs[REG_SOURCE_SIZE][31:16]);
    tw = dimension(regs[REG_TARGET_SIZE][15:0]);
    th = dimension(regs[REG_TARGET_SIZE][31:16]);
    if (b.offset_x >= tw || b.offset_y >= th) return -1;
    return ((b.offset_y * sh / th) * sw + b.offset_x * sw / tw) % STORE_WORDS;
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] bg,
                                       input logic [7:0] a);
    return 8'((c * a) / 255 + (bg * (255 - a)) / 255);
  endfunction

  function automatic pixel_write_t predict_write(input beat_t b);
    pixel_write_t r;
    logic [31:0] w;
    logic [7:0] a;
    logic [23:0] bg;
    int e, px, py, fw, fh;
    r = '0;
    e = source_entry(b);
    if (e < 0) return r;
    w = src_words[e];
    a = w[31:24];
    if (a == ALPHA_CLEAR) return r;
    bg = regs[REG_BACKGROUND][23:0];
    if (a == ALPHA_OPAQUE) r.pixel_colour = w;
    else r.pixel_colour = {ALPHA_OPAQUE, blend(w[23:16], bg[23:16], a),
                           blend(w[15:8], bg[15:8], a), blend(w[7:0], bg[7:0], a)};
    px = $signed(regs[REG_TARGET_ORIGIN][15:0]) + int'(b.offset_x);
    py = $signed(regs[REG_TARGET_ORIGIN][31:16]) + int'(b.offset_y);
    fw = regs[REG_FRAME_SIZE][15:0];
    fh = regs[REG_FRAME_SIZE][31:16];
    if (px < $signed(regs[REG_CLIP_MIN][15:0]) || px >= $signed(regs[REG_CLIP_MAX][15:0]) ||
        py < $signed(regs[REG_CLIP_MIN][31:16]) || py >= $signed(regs[REG_CLIP_MAX][31:16]) ||
        px < 0 || px >= fw || py < 0 || py >= fh) begin
      r.pixel_colour = '0;
      return r;
    end
    r.write_enable  = 1'b1;
    r.frame_address = 24'(py * fw + px);
    return r;
  endfunction

  task automatic queue_load(input int idx, input logic [31:0] w);
    beat_t b;
    b = '0;
    b.op = OP_LOAD;
    b.load_index = 12'(idx);
    b.load_word = w;
    src_loaded[idx] = 1'b1;
    pending_beats.push_back(b);
  endtask

  task automatic queue_plot(input int ox, input int oy);
    beat_t b;
    b = '0;
    b.op = OP_PLOT;
    b.offset_x = 12'(ox);
    b.offset_y = 12'(oy);
    b.load_index = 12'($urandom);
    b.load_word = $urandom;
    pending_beats.push_back(b);
  endtask

  // load the picked store entry first if it has not been loaded, then plot
  task automatic queue_safe_plot(input int ox, input int oy);
    beat_t b;
    int e;
    b = '0;
    b.offset_x = 12'(ox);
    b.offset_y = 12'(oy);
    e = source_entry(b);
    if (e >= 0 && !src_loaded[e]) queue_load(e, $urandom);
    queue_plot(ox, oy);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx != REG_UNUSED) regs[idx] = (idx == REG_BACKGROUND) ? {8'd0, d[23:0]} : d;
  endtask

  task automatic drain_pipe();
    while (pending_beats.size() != 0 || expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // beat driver: bursts and gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (in_op == OP_PLOT) begin
          expected_writes.push_back(predict_write({in_op, in_load_index, in_load_word,
                                                   in_offset_x, in_offset_y}));
          plots++;
        end else begin
          if (in_load_index < STORE_WORDS) src_words[in_load_index] = in_load_word;
          loads++;
        end
        void'(pending_beats.pop_front());
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_beats.size() > (start && !busy ? 0 : 0) &&
                     pending_beats.size() != 0) begin
          start <= 1'b1;
          {in_op, in_load_index, in_load_word, in_offset_x, in_offset_y} <= pending_beats[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pixel_write_t got, want;
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("** scaled_alpha_bitmap_blit_unit: FAILED **");
      $finish;
    end
    if (rst_n && out_strobe) begin
      got = {out_write_enable, out_frame_address, out_pixel_colour};
      if (got.write_enable) writes_seen++;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = expected_writes.pop_front();
        if (got.write_enable !== want.write_enable) begin
          $display("%0t: write_enable exp %h got %h", $time, want.write_enable,
                   got.write_enable);
          errors++;
        end
        if (got.frame_address !== want.frame_address) begin
          $display("%0t: frame_address exp %h got %h", $time, want.frame_address,
                   got.frame_address);
          errors++;
        end
        if (got.pixel_colour !== want.pixel_colour) begin
          $display("%0t: pixel_colour exp %h got %h", $time, want.pixel_colour,
                   got.pixel_colour);
          errors++;
        end
      end
    end
  end

  task automatic random_phase(input int n);
    int tw, th, k;
    tw = dimension(regs[REG_TARGET_SIZE][15:0]);
    th = dimension(regs[REG_TARGET_SIZE][31:16]);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1: queue_load($urandom_range(0, STORE_WORDS - 1), $urandom);
        2: begin
          // offset anywhere in the field, often out of range
          queue_safe_plot($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
        3: queue_load($urandom_range(0, STORE_WORDS - 1),
                      {($urandom_range(0, 1) ? ALPHA_OPAQUE : ALPHA_CLEAR), 24'($urandom)});
        default: queue_safe_plot($urandom_range(0, tw - 1), $urandom_range(0, th - 1));
      endcase
      if (pending_beats.size() == 0) continue;
    end
  endtask

  task automatic run_setting(input logic [31:0] ss, input logic [31:0] ts,
                             input logic [31:0] org, input logic [31:0] bg,
                             input logic [31:0] cmin, input logic [31:0] cmax,
                             input logic [31:0] fs, input int n);
    drain_pipe();
    write_reg(REG_SOURCE_SIZE, ss);
    write_reg(REG_TARGET_SIZE, ts);
    write_reg(REG_TARGET_ORIGIN, org);
    write_reg(REG_BACKGROUND, bg);
    write_reg(REG_CLIP_MIN, cmin);
    write_reg(REG_CLIP_MAX, cmax);
    write_reg(REG_FRAME_SIZE, fs);
    random_phase(n);
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_LOAD;
    in_load_index = '0;
    in_load_word = '0;
    in_offset_x = '0;
    in_offset_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SOURCE_SIZE;
    cfg_data = '0;
    errors = 0; plots = 0; loads = 0; writes_seen = 0;
    burst_left = 0; gap_left = 0; cycle_count = 0;
    regs[REG_SOURCE_SIZE] = SIZE_RESET;
    regs[REG_TARGET_SIZE] = SIZE_RESET;
    regs[REG_TARGET_ORIGIN] = '0;
    regs[REG_BACKGROUND] = '0;
    regs[REG_CLIP_MIN] = '0;
    regs[REG_CLIP_MAX] = FRAME_RESET;
    regs[REG_FRAME_SIZE] = FRAME_RESET;
    for (i = 0; i < STORE_WORDS; i++) begin
      src_words[i] = '0;
      src_loaded[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, alpha extremes, blend, offsets at edges
    queue_load(0, 32'hFF123456);
    queue_load(4095, 32'h00FFFFFF);
    queue_load(65, 32'h80FF8001);
    queue_load(63 * 64 + 63, 32'h01FFFFFF);
    queue_load(1, 32'hFEFFFFFF);
    queue_plot(0, 0);
    queue_plot(1, 1);
    queue_plot(63, 63);
    queue_plot(1, 0);
    queue_plot(64, 0);
    queue_plot(0, 64);
    queue_plot(4095, 4095);
    drain_pipe();
    write_reg(REG_BACKGROUND, 32'hFFFFFFFF);
    write_reg(REG_UNUSED, 32'hDEADBEEF);
    queue_plot(1, 1);
    queue_plot(63, 63);
    queue_plot(1, 0);
    random_phase(110);

    // tiny source stretched, negative origin, tight clip
    run_setting(32'h0004_0004, 32'h0020_0020, 32'hFFF0_FFF8, 32'h00A0_5020,
                32'h0002_0003, 32'h0018_001C, 32'h0040_0040, 190);
    // dimensions of zero act as one, origin near frame edge
    run_setting(32'h0000_0000, 32'h0000_0003, 32'h0020_0030, 32'h0012_3456,
                32'h8000_8000, 32'h7FFF_7FFF, 32'h0038_0034, 110);
    // oversize dimensions clamp, address overflow from a wide frame
    run_setting(32'hFFFF_FFFF, 32'h1000_1000, 32'h0F00_0700, 32'h00FF_FFFF,
                32'h0000_0000, 32'h7FFF_7FFF, 32'hFFFF_FFFF, 220);
    // downscale with empty clip, then a frame of zero height
    run_setting(32'h0040_0040, 32'h0010_0008, 32'h0000_0000, 32'h0000_00FF,
                32'h0010_0010, 32'h0010_0010, 32'h1000_1000, 75);
    run_setting(32'h0030_0050, 32'h00C0_0030, 32'h0005_0002, 32'h007F_8001,
                32'hFFFF_FFFE, 32'h0100_0100, 32'h0000_0100, 75);
    // wide source, indices reaching the top of the store
    run_setting(32'h0008_0200, 32'h0100_0100, 32'h0001_0001, 32'h0055_AA33,
                32'h0000_0000, 32'h1000_1000, 32'h1000_1000, 370);

    drain_pipe();
    $display("covered %0d plot beats and %0d load beats over seven register settings",
             plots, loads);
    $display("%0d framebuffer writes checked, %0d mismatches", writes_seen, errors);
    if (errors == 0) begin
      $display("** scaled_alpha_bitmap_blit_unit: PASSED **");
    end else begin
      $display("** scaled_alpha_bitmap_blit_unit: FAILED **");
    end
    $finish;
  end

endmodule
